/* src/csvt_pkg.sv */
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants of the CSV tokenizer with backslash escapes.
// ----------------------------------------------------------------------------
package csvt_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_CELL = 2'd1,
    KIND_ROW  = 2'd2
  } kind_e;

  // Character codes
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChC      = 8'h63;
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;

  localparam logic [7:0] ColorReset = 8'd28;

  // Most results one input byte can cause
  localparam int unsigned MaxRes = 3;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);
  localparam int unsigned ResIdxW = $clog2(MaxRes);

  // One result
  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } res_t;

  // All results of one input byte
  typedef struct packed {
    res_t [MaxRes-1:0]  res;
    logic [ResCntW-1:0] cnt;
  } bundle_t;

  // Hex digit decode: {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

endpackage

/* src/csvt_front.sv */
// ----------------------------------------------------------------------------
// csvt_front
// Accepts raw bytes, tracks quoting and escape state, and builds the bundle
// of results each byte causes.
// ----------------------------------------------------------------------------
module csvt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output csvt_pkg::bundle_t q_data_o
);

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_BSL  = 2'd1,
    ESC_HEX  = 2'd2
  } esc_e;

  logic [7:0] color_code_q;
  logic       in_quotes_q, in_quotes_d;
  logic       qpend_q, qpend_d;
  logic       cstart_q, cstart_d;
  logic       rstart_q, rstart_d;
  esc_e       esc_q, esc_d;
  logic       hcnt_q, hcnt_d;
  logic [7:0] hacc_q, hacc_d;
  logic       trunc_q, trunc_d;

  logic              accept;
  csvt_pkg::bundle_t bnd;

  function automatic csvt_pkg::bundle_t add_res(input csvt_pkg::bundle_t b,
                                                input logic [7:0] d,
                                                input csvt_pkg::kind_e k);
    csvt_pkg::bundle_t r;
    r = b;
    if (r.cnt < csvt_pkg::ResCntW'(csvt_pkg::MaxRes)) begin
      r.res[r.cnt[csvt_pkg::ResIdxW-1:0]].data = d;
      r.res[r.cnt[csvt_pkg::ResIdxW-1:0]].kind = k;
      r.cnt = r.cnt + 1'b1;
    end
    return r;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign q_push_o   = accept & (bnd.cnt != '0);
  assign q_data_o   = bnd;

  always_comb begin
    logic            handled;
    logic            do_feed;
    logic [7:0]      fc;
    logic            do_end;
    csvt_pkg::kind_e ek;
    logic            do_idle;
    logic [4:0]      hx;

    in_quotes_d = in_quotes_q;
    qpend_d     = qpend_q;
    cstart_d    = cstart_q;
    rstart_d    = rstart_q;
    esc_d       = esc_q;
    hcnt_d      = hcnt_q;
    hacc_d      = hacc_q;
    trunc_d     = trunc_q;
    bnd         = '0;
    handled     = 1'b0;
    do_feed     = 1'b0;
    fc          = in_byte_i;
    do_end      = 1'b0;
    ek          = csvt_pkg::KIND_CELL;
    do_idle     = 1'b0;
    hx          = csvt_pkg::hex_digit(in_byte_i);

    // Resolve a quote seen inside quoting
    if (qpend_q) begin
      qpend_d = 1'b0;
      if (in_byte_i == csvt_pkg::ChQuote) begin
        do_feed = 1'b1;
        handled = 1'b1;
      end else begin
        in_quotes_d = 1'b0;
      end
    end

    if (!handled) begin
      priority if (in_byte_i == csvt_pkg::ChQuote) begin
        if (in_quotes_d) begin
          if (in_last_i) in_quotes_d = 1'b0;
          else qpend_d = 1'b1;
        end else if (!cstart_q) begin
          in_quotes_d = 1'b1;
        end
      end else if (in_byte_i == csvt_pkg::ChComma) begin
        if (!in_quotes_d) begin
          do_end = 1'b1;
          ek     = csvt_pkg::KIND_CELL;
        end else begin
          do_feed = 1'b1;
        end
      end else if (in_byte_i == csvt_pkg::ChCr) begin
        do_feed = 1'b0;
      end else if (in_byte_i == csvt_pkg::ChLf && !in_quotes_d) begin
        do_end = 1'b1;
        ek     = csvt_pkg::KIND_ROW;
      end else begin
        do_feed = 1'b1;
      end
    end

    // Escape stage for one cell byte
    if (do_feed) begin
      cstart_d = 1'b1;
      if (!trunc_d) begin
        unique case (esc_d)
          ESC_BSL: begin
            esc_d = ESC_IDLE;
            priority if (fc == csvt_pkg::ChNul) trunc_d = 1'b1;
            else if (fc == csvt_pkg::ChN) bnd = add_res(bnd, csvt_pkg::ChLf,
                                                        csvt_pkg::KIND_DATA);
            else if (fc == csvt_pkg::ChR) bnd = add_res(bnd, csvt_pkg::ChCr,
                                                        csvt_pkg::KIND_DATA);
            else if (fc == csvt_pkg::ChT) bnd = add_res(bnd, csvt_pkg::ChTab,
                                                        csvt_pkg::KIND_DATA);
            else if (fc == csvt_pkg::ChC) bnd = add_res(bnd, color_code_q,
                                                        csvt_pkg::KIND_DATA);
            else if (fc == csvt_pkg::ChX) begin
              esc_d  = ESC_HEX;
              hcnt_d = 1'b0;
              hacc_d = 8'd0;
            end else if (fc == csvt_pkg::ChLf) begin
              esc_d = ESC_IDLE;
            end else begin
              bnd = add_res(bnd, fc, csvt_pkg::KIND_DATA);
            end
          end
          ESC_HEX: begin
            if (hx[4]) begin
              hacc_d = {hacc_d[3:0], hx[3:0]};
              if (!hcnt_d) begin
                hcnt_d = 1'b1;
              end else begin
                esc_d  = ESC_IDLE;
                hcnt_d = 1'b0;
                if (hacc_d != 8'd0) bnd = add_res(bnd, hacc_d, csvt_pkg::KIND_DATA);
              end
            end else begin
              esc_d   = ESC_IDLE;
              hcnt_d  = 1'b0;
              if (hacc_d != 8'd0) bnd = add_res(bnd, hacc_d, csvt_pkg::KIND_DATA);
              do_idle = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase
        if (do_idle) begin
          priority if (fc == csvt_pkg::ChNul) trunc_d = 1'b1;
          else if (fc == csvt_pkg::ChBslash) esc_d = ESC_BSL;
          else bnd = add_res(bnd, fc, csvt_pkg::KIND_DATA);
        end
      end
    end

    // Close a cell on comma or LF
    if (do_end) begin
      if (!trunc_d && esc_d == ESC_HEX && hacc_d != 8'd0)
        bnd = add_res(bnd, hacc_d, csvt_pkg::KIND_DATA);
      esc_d    = ESC_IDLE;
      hcnt_d   = 1'b0;
      hacc_d   = 8'd0;
      trunc_d  = 1'b0;
      cstart_d = 1'b0;
      bnd      = add_res(bnd, 8'd0, ek);
      rstart_d = (ek == csvt_pkg::KIND_CELL);
    end

    // Buffer end: close what is open, then start over
    if (in_last_i) begin
      if (cstart_d || rstart_d) begin
        if (!trunc_d && esc_d == ESC_HEX && hacc_d != 8'd0)
          bnd = add_res(bnd, hacc_d, csvt_pkg::KIND_DATA);
        bnd = add_res(bnd, 8'd0, csvt_pkg::KIND_ROW);
      end
      in_quotes_d = 1'b0;
      qpend_d     = 1'b0;
      cstart_d    = 1'b0;
      rstart_d    = 1'b0;
      esc_d       = ESC_IDLE;
      hcnt_d      = 1'b0;
      hacc_d      = 8'd0;
      trunc_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_code_q <= csvt_pkg::ColorReset;
      in_quotes_q  <= 1'b0;
      qpend_q      <= 1'b0;
      cstart_q     <= 1'b0;
      rstart_q     <= 1'b0;
      esc_q        <= ESC_IDLE;
      hcnt_q       <= 1'b0;
      hacc_q       <= 8'd0;
      trunc_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_code_q <= cfg_wdata_i;
      end
      if (accept) begin
        in_quotes_q <= in_quotes_d;
        qpend_q     <= qpend_d;
        cstart_q    <= cstart_d;
        rstart_q    <= rstart_d;
        esc_q       <= esc_d;
        hcnt_q      <= hcnt_d;
        hacc_q      <= hacc_d;
        trunc_q     <= trunc_d;
      end
    end
  end

endmodule

/* src/csvt_queue.sv */
// ----------------------------------------------------------------------------
// csvt_queue
// Two-entry queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module csvt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csvt_pkg::bundle_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output csvt_pkg::bundle_t head_o
);

  csvt_pkg::bundle_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* src/csvt_back.sv */
// ----------------------------------------------------------------------------
// csvt_back
// Walks the head bundle one result per beat and drives the output channel.
// ----------------------------------------------------------------------------
module csvt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  csvt_pkg::bundle_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic [1:0]        out_kind_o,
  output logic              run_last_o
);

  logic [csvt_pkg::ResIdxW-1:0] idx_q;
  logic                         fire;
  logic                         at_end;

  assign at_end      = (csvt_pkg::ResCntW'(idx_q) ==
                        head_i.cnt - csvt_pkg::ResCntW'(1));
  assign fire        = head_valid_i & ~out_stall_i;
  assign pop_o       = fire & at_end;
  assign out_valid_o = head_valid_i;
  assign out_byte_o  = head_i.res[idx_q].data;
  assign out_kind_o  = head_i.res[idx_q].kind;
  assign run_last_o  = at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      if (at_end) idx_q <= '0;
      else idx_q <= idx_q + 1'b1;
    end
  end

endmodule

/* src/csv_tokenizer_with_escapes_core.sv */
// ----------------------------------------------------------------------------
// csv_tokenizer_with_escapes_core
// CSV tokenizer with backslash escapes, one raw byte per beat in.
// ----------------------------------------------------------------------------
// Takes one byte of a CSV buffer per beat and emits decoded cell bytes,
// end-of-cell markers (kind 1) and end-of-row markers (kind 2); run_last_o
// flags the final result caused by an input byte. The front stage classifies
// each byte in the cycle it is accepted: quoting, CR dropping, comma and LF
// splitting, and the escape stage (\n \r \t \c, \xHH, backslash-LF) all
// resolve combinationally, so a byte is accepted every cycle while the result
// queue has room. Each byte yields zero to three results; the back stage
// sends them one beat per cycle while out_stall_i is low, so output bandwidth
// sets the sustained rate: one byte per cycle for bytes with at most one
// result, a lower rate for bytes with more. Bytes with no result never
// reach the queue. A two-entry queue sits between the stages, so input and
// output stall independently. The color_escape_code register (reset 28) is
// written via cfg_we_i and takes effect on the next accepted byte; write it
// only while the block is idle.
// ----------------------------------------------------------------------------
module csv_tokenizer_with_escapes_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_kind_o,
  output logic       run_last_o
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  csvt_pkg::bundle_t q_in;
  csvt_pkg::bundle_t q_head;

  // Classify bytes and build result bundles
  csvt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_in)
  );

  // Hold bundles between the two stages
  csvt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Serialize each bundle onto the output channel
  csvt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_kind_o   (out_kind_o),
    .run_last_o   (run_last_o)
  );

endmodule

/* tb/sv/csv_tokenizer_with_escapes_core_checker.sv */
// ----------------------------------------------------------------------------
// csv_tokenizer_with_escapes_core_checker
// Watches both channels of the CSV tokenizer, predicts and compares results.
// ----------------------------------------------------------------------------
// Each accepted input beat runs through a local tokenizer and escape decoder.
// The tokens it produces are queued in order. Each accepted output beat is
// checked field by field against the oldest queued token.
// ----------------------------------------------------------------------------
module csv_tokenizer_with_escapes_core_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic [1:0] out_kind_i,
  input  logic       run_last_i,
  output int         mismatch_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_BSLASH,
    ESC_HEX
  } esc_e;

  typedef struct packed {
    logic [7:0]      data;
    csvt_pkg::kind_e kind;
    logic            last;
  } token_t;

  // Local copy of the register and the tokenizer state
  logic [7:0] color_code = csvt_pkg::ColorReset;
  logic       quoted     = 1'b0;
  logic       quote_seen = 1'b0;
  logic       cell_open  = 1'b0;
  logic       row_open   = 1'b0;
  esc_e       esc        = ESC_IDLE;
  logic       hex_count  = 1'b0;
  logic [7:0] hex_val    = 8'h00;
  logic       truncated  = 1'b0;

  token_t burst_q[$];     // tokens of the beat being decoded
  token_t expected_q[$];  // tokens still owed by the block

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  function automatic void clear_parse();
    quoted     = 1'b0;
    quote_seen = 1'b0;
    cell_open  = 1'b0;
    row_open   = 1'b0;
    esc        = ESC_IDLE;
    hex_count  = 1'b0;
    hex_val    = 8'h00;
    truncated  = 1'b0;
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void put_token(input logic [7:0] d, input csvt_pkg::kind_e k);
    token_t t;
    t.data = d;
    t.kind = k;
    t.last = 1'b0;
    if (burst_q.size() < int'(csvt_pkg::MaxRes)) burst_q.push_back(t);
  endfunction

  function automatic void decode_plain(input logic [7:0] c);
    if (c == csvt_pkg::ChNul) begin
      truncated = 1'b1;
    end else if (c == csvt_pkg::ChBslash) begin
      esc = ESC_BSLASH;
    end else begin
      put_token(c, csvt_pkg::KIND_DATA);
    end
  endfunction

  // Push one cell byte through the escape decoder
  function automatic void feed_cell(input logic [7:0] c);
    int nib;
    cell_open = 1'b1;
    if (truncated) return;
    case (esc)
      ESC_BSLASH: begin
        esc = ESC_IDLE;
        if (c == csvt_pkg::ChNul) truncated = 1'b1;
        else if (c == csvt_pkg::ChN) put_token(csvt_pkg::ChLf, csvt_pkg::KIND_DATA);
        else if (c == csvt_pkg::ChR) put_token(csvt_pkg::ChCr, csvt_pkg::KIND_DATA);
        else if (c == csvt_pkg::ChT) put_token(csvt_pkg::ChTab, csvt_pkg::KIND_DATA);
        else if (c == csvt_pkg::ChC) put_token(color_code, csvt_pkg::KIND_DATA);
        else if (c == csvt_pkg::ChX) begin
          esc       = ESC_HEX;
          hex_count = 1'b0;
          hex_val   = 8'h00;
        end else if (c != csvt_pkg::ChLf) put_token(c, csvt_pkg::KIND_DATA);
      end
      ESC_HEX: begin
        nib = hex_nibble(c);
        if (nib >= 0) begin
          hex_val = {hex_val[3:0], 4'(nib)};
          if (!hex_count) begin
            hex_count = 1'b1;
          end else begin
            esc       = ESC_IDLE;
            hex_count = 1'b0;
            if (hex_val != 8'h00) put_token(hex_val, csvt_pkg::KIND_DATA);
          end
        end else begin
          // non-hex byte ends the sequence and is decoded on its own
          esc       = ESC_IDLE;
          hex_count = 1'b0;
          if (hex_val != 8'h00) put_token(hex_val, csvt_pkg::KIND_DATA);
          decode_plain(c);
        end
      end
      default: decode_plain(c);
    endcase
  endfunction

  function automatic void close_cell(input csvt_pkg::kind_e k);
    if (!truncated && esc == ESC_HEX && hex_val != 8'h00)
      put_token(hex_val, csvt_pkg::KIND_DATA);
    esc       = ESC_IDLE;
    hex_count = 1'b0;
    hex_val   = 8'h00;
    truncated = 1'b0;
    cell_open = 1'b0;
    put_token(8'h00, k);
    row_open  = (k == csvt_pkg::KIND_CELL);
  endfunction

  function automatic void tokenize_beat(input logic [7:0] b, input logic last);
    logic taken;
    taken = 1'b0;
    burst_q.delete();
    if (quote_seen) begin
      quote_seen = 1'b0;
      if (b == csvt_pkg::ChQuote) begin
        feed_cell(csvt_pkg::ChQuote);
        taken = 1'b1;
      end else begin
        quoted = 1'b0;
      end
    end
    if (!taken) begin
      if (b == csvt_pkg::ChQuote) begin
        if (quoted) begin
          if (last) quoted = 1'b0;
          else quote_seen = 1'b1;
        end else if (!cell_open) begin
          quoted = 1'b1;
        end
      end else if (b == csvt_pkg::ChComma) begin
        if (!quoted) close_cell(csvt_pkg::KIND_CELL);
        else feed_cell(b);
      end else if (b == csvt_pkg::ChCr) begin
        // dropped everywhere
      end else if (b == csvt_pkg::ChLf && !quoted) begin
        close_cell(csvt_pkg::KIND_ROW);
      end else begin
        feed_cell(b);
      end
    end
    if (last) begin
      if (cell_open || row_open) close_cell(csvt_pkg::KIND_ROW);
      clear_parse();
    end
    if (burst_q.size() > 0) burst_q[burst_q.size()-1].last = 1'b1;
    foreach (burst_q[i]) expected_q.push_back(burst_q[i]);
  endfunction

  function automatic void check_result();
    token_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, got byte %02h kind %0d last %0b",
               $time, out_byte_i, out_kind_i, run_last_i);
      mismatch_count_o++;
      return;
    end
    want = expected_q.pop_front();
    if (out_byte_i !== want.data) begin
      $display("%0t: out_byte expected %02h, got %02h", $time, want.data, out_byte_i);
      mismatch_count_o++;
    end
    if (out_kind_i !== want.kind) begin
      $display("%0t: out_kind expected %0d, got %0d", $time, want.kind, out_kind_i);
      mismatch_count_o++;
    end
    if (run_last_i !== want.last) begin
      $display("%0t: run_last expected %0b, got %0b", $time, want.last, run_last_i);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_code = csvt_pkg::ColorReset;
      clear_parse();
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) color_code = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) tokenize_beat(in_byte_i, in_last_i);
      if (out_valid_i && !out_stall_i) check_result();
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/sv/csv_tokenizer_with_escapes_core_tb.sv */
// ----------------------------------------------------------------------------
// csv_tokenizer_with_escapes_core_tb
// Stimulus and verdict for the CSV tokenizer with backslash escapes.
// ----------------------------------------------------------------------------
// Feeds short hand-made buffers that hit quoting, escapes and the cell repairs,
// then random CSV-like buffers under several color codes. Both channels idle in
// random bursts; one long output hold-off fills the block up. A checker beside
// the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module csv_tokenizer_with_escapes_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       run_last;

  int mismatches;
  int pending;

  // Pacing controls shared by the sender and the receiver
  bit sender_gaps     = 1'b1;
  bit receiver_stalls = 1'b1;
  bit hold_request    = 1'b0;
  int bytes_sent      = 0;

  logic [7:0] frame_q[$];  // next buffer to send

  csv_tokenizer_with_escapes_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_byte_i  (in_byte),
    .in_last_i  (in_last),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_byte_o (out_byte),
    .out_kind_o (out_kind),
    .run_last_o (run_last)
  );

  csv_tokenizer_with_escapes_core_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_byte_i       (in_byte),
    .in_last_i       (in_last),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_byte_i      (out_byte),
    .out_kind_i      (out_kind),
    .run_last_i      (run_last),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always #10 clk = ~clk;

  // Offer one beat and hold it until the block takes it. Entered and left at
  // a rising edge; the handshake is judged at the falling edge, where the
  // stall is settled, and the beat lands at the following rising edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && (i == s.len() - 1));
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Write the color code only once the block has gone quiet and drained.
  task automatic cfg_write(input logic [7:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Build a CSV-like buffer: printable bytes, separators, escapes and quoted
  // cells with random content, with some raw noise mixed in.
  function automatic void make_frame();
    int    target;
    string hexdig;
    hexdig = "0123456789abcdefABCDEF";
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 10);
    frame_q.delete();
    while (frame_q.size() < target) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: frame_q.push_back(8'($urandom_range(32, 126)));
        6, 7: frame_q.push_back(csvt_pkg::ChComma);
        8:    frame_q.push_back(csvt_pkg::ChLf);
        9:    frame_q.push_back(csvt_pkg::ChCr);
        10:   frame_q.push_back(csvt_pkg::ChQuote);
        11: begin
          frame_q.push_back(csvt_pkg::ChBslash);
          case ($urandom_range(0, 5))
            0:       frame_q.push_back(csvt_pkg::ChN);
            1:       frame_q.push_back(csvt_pkg::ChR);
            2:       frame_q.push_back(csvt_pkg::ChT);
            3:       frame_q.push_back(csvt_pkg::ChC);
            4:       frame_q.push_back(csvt_pkg::ChLf);
            default: frame_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        12: begin
          frame_q.push_back(csvt_pkg::ChBslash);
          frame_q.push_back(csvt_pkg::ChX);
          repeat ($urandom_range(1, 2)) frame_q.push_back(hexdig[$urandom_range(0, 21)]);
        end
        13: begin
          // hex cut short by whatever follows
          frame_q.push_back(csvt_pkg::ChBslash);
          frame_q.push_back(csvt_pkg::ChX);
          frame_q.push_back(hexdig[$urandom_range(0, 21)]);
          frame_q.push_back(8'($urandom_range(0, 255)));
        end
        14: frame_q.push_back(csvt_pkg::ChNul);
        15: frame_q.push_back(8'($urandom_range(0, 255)));
        16: begin
          frame_q.push_back(csvt_pkg::ChQuote);
          frame_q.push_back(csvt_pkg::ChQuote);
        end
        default: begin
          frame_q.push_back(csvt_pkg::ChQuote);
          repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom_range(32, 126)));
          frame_q.push_back(csvt_pkg::ChQuote);
        end
      endcase
    end
  endfunction

  // Send buffers until the byte count reaches the goal; most end with the
  // last flag, the rest run on into the next buffer.
  task automatic send_frames(input int goal);
    bit close;
    while (bytes_sent < goal) begin
      make_frame();
      close = ($urandom_range(0, 4) != 0);
      foreach (frame_q[i]) send_byte(frame_q[i], close && (i == frame_q.size() - 1));
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        out_stall <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed buffers under the top color code
    cfg_write(8'hFF);
    // open quote, doubled quote, then a closing quote as the final byte
    send_text("\"\"\"\"", 1'b1);
    // color escape, stray quote, hex cut short, partial hex flushed by NUL,
    // truncated tail, then a trailing backslash before the row end
    send_text("\\c\"\\x4g\\x5", 1'b0);
    send_byte(csvt_pkg::ChNul, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text(",\\\n", 1'b1);
    // control escapes and an unfinished hex value at buffer end
    send_text("\\n\\r\\t\\xA", 1'b1);
    // lone CR closes nothing and yields no result
    send_text("\r", 1'b1);

    // Random part, phase one: color code zero and a long output hold-off
    cfg_write(8'h00);
    send_frames(bytes_sent + 60);
    hold_request = 1'b1;
    sender_gaps  = 1'b0;
    send_frames(bytes_sent + 30);
    sender_gaps  = 1'b1;
    send_frames(bytes_sent + 30);

    // Phase two: random color code
    cfg_write(8'($urandom_range(1, 254)));
    send_frames(bytes_sent + 80);

    // Phase three: back to the reset code, no idling on either side
    cfg_write(csvt_pkg::ColorReset);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    send_frames(bytes_sent + 100);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS csv_tokenizer_with_escapes_core");
    end else begin
      $display("FAIL csv_tokenizer_with_escapes_core");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("FAIL csv_tokenizer_with_escapes_core");
    $finish;
  end

endmodule
